@@ rtl/core/pfr_pkg.sv @@
// ----------------------------------------------------------------------------
// pfr_pkg: shared types and constants of the page framebuffer refresh block
// Screen geometry, action and operation codes, display command bytes and the
// command word that travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package pfr_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH = 128;
  localparam int PAGE_COUNT   = 4;
  localparam int ROWS         = PAGE_COUNT * 8;
  localparam int HEADER_LEN   = 4;
  localparam int PAGE_LEN     = HEADER_LEN + SCREEN_WIDTH;
  localparam int MEM_DEPTH    = SCREEN_WIDTH * PAGE_COUNT;

  // Derived widths
  localparam int COORD_W = 8;
  localparam int BOUND_W = COORD_W + 1;
  localparam int COL_W   = $clog2(SCREEN_WIDTH);
  localparam int PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int ADDR_W  = PAGE_W + COL_W;
  localparam int OFF_W   = $clog2(PAGE_LEN);

  // Command queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Input action codes
  localparam logic [1:0] ACT_PIXEL = 2'd0;
  localparam logic [1:0] ACT_RECT  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_FETCH = 2'd3;

  // Back-end operation codes
  localparam logic [1:0] OP_RECT  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_FETCH = 2'd2;

  // Display controller command bytes
  localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  // Header byte positions within a page
  localparam logic [1:0] HDR_PAGE_CMD = 2'd0;
  localparam logic [1:0] HDR_PAGE_NUM = 2'd1;
  localparam logic [1:0] HDR_COL_LOW  = 2'd2;
  localparam logic [1:0] HDR_COL_HIGH = 2'd3;

  // One queued operation; a pixel is a one-by-one rectangle
  typedef struct packed {
    logic [1:0]        op;
    logic [COL_W-1:0]  col_first;
    logic [COL_W-1:0]  col_last;
    logic [PAGE_W-1:0] page_first;
    logic [PAGE_W-1:0] page_last;
    logic [2:0]        bit_lo;
    logic [2:0]        bit_hi;
    logic              on;
  } pfr_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/page_framebuffer_refresh.sv @@
// A refresh fetch passes the command queue, the fetch state of the sequencer (page memory
// read) and the output beat register; it leaves the queue only when that register is free.
// A single pixel is dispatched, read and written; a rectangle is dispatched, then read and
// written once per covered page byte. A screen clear is dispatched, then sweeps all 512
// bytes. Reset is synchronous; after it the same clearing sweep runs with s_tready low.
// ----------------------------------------------------------------------------
// page_framebuffer_refresh: monochrome page framebuffer with refresh stream
// Draws pixels and rectangles into a 128x32 page memory and streams refresh
// frames of command and data bytes to a display controller.
// ----------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_refresh import pfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // x_start, x_end, y_start, y_end, pixel_on, zero pad
  input  wire logic [1:0]  s_tuser,  // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // out_byte
  output logic [0:0]       m_tuser,  // is_data
  output logic             m_tlast   // frame_last
);

  pfr_cmd_t push_cmd;
  pfr_cmd_t q_cmd;
  logic     push;
  logic     pop;
  logic     q_valid;
  logic     q_full;
  logic     init_busy;
  logic     is_data;

  // Classifier
  pfr_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .action    (s_tuser),
    .x_start   (s_tdata[7:0]),
    .x_end     (s_tdata[15:8]),
    .y_start   (s_tdata[23:16]),
    .y_end     (s_tdata[31:24]),
    .pixel_on  (s_tdata[32]),
    .q_full    (q_full),
    .init_busy (init_busy),
    .push      (push),
    .cmd       (push_cmd)
  );

  // Command queue
  pfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_cmd    (q_cmd)
  );

  // Framebuffer sequencer
  pfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .pop        (pop),
    .init_busy  (init_busy),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_byte   (m_tdata),
    .is_data    (is_data),
    .frame_last (m_tlast)
  );

  assign m_tuser[0] = is_data;

endmodule

`default_nettype wire

@@ rtl/core/pfr_front.sv @@
// ----------------------------------------------------------------------------
// pfr_front: input beat classifier
// Clips pixel and rectangle requests to the screen, turns them into
// page/column ranges with bit bounds, and drops requests that draw nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_front import pfr_pkg::*; (
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [1:0]         action,
  input  wire logic [COORD_W-1:0] x_start,
  input  wire logic [COORD_W-1:0] x_end,
  input  wire logic [COORD_W-1:0] y_start,
  input  wire logic [COORD_W-1:0] y_end,
  input  wire logic               pixel_on,
  input  wire logic               q_full,
  input  wire logic               init_busy,
  output logic                    push,
  output pfr_cmd_t                cmd
);

  logic [BOUND_W-1:0] xs9, ys9, xe9, ye9, xe_c, ye_c, xl, yl;
  logic               draw_ok;
  logic               keep;

  // Bounds: a pixel covers one column and one row
  always_comb begin
    xs9 = {1'b0, x_start};
    ys9 = {1'b0, y_start};
    if (action == ACT_PIXEL) begin
      xe9 = xs9 + BOUND_W'(1);
      ye9 = ys9 + BOUND_W'(1);
    end else begin
      xe9 = {1'b0, x_end};
      ye9 = {1'b0, y_end};
    end
    xe_c = (xe9 > BOUND_W'(SCREEN_WIDTH)) ? BOUND_W'(SCREEN_WIDTH) : xe9;
    ye_c = (ye9 > BOUND_W'(ROWS)) ? BOUND_W'(ROWS) : ye9;
    xl   = xe_c - BOUND_W'(1);
    yl   = ye_c - BOUND_W'(1);
    draw_ok = (xe_c > xs9) && (ye_c > ys9);
  end

  // Command word
  always_comb begin
    case (action)
      ACT_PIXEL, ACT_RECT: cmd.op = OP_RECT;
      ACT_CLEAR:           cmd.op = OP_CLEAR;
      default:             cmd.op = OP_FETCH;
    endcase
    cmd.col_first  = xs9[COL_W-1:0];
    cmd.col_last   = xl[COL_W-1:0];
    cmd.page_first = ys9[PAGE_W+2:3];
    cmd.page_last  = yl[PAGE_W+2:3];
    cmd.bit_lo     = ys9[2:0];
    cmd.bit_hi     = yl[2:0];
    cmd.on         = pixel_on;
  end

  // Accept while the queue has room and the power-on clear is done
  assign keep     = (action == ACT_CLEAR) || (action == ACT_FETCH) || draw_ok;
  assign s_tready = !q_full && !init_busy;
  assign push     = s_tvalid && s_tready && keep;

endmodule

`default_nettype wire

@@ rtl/core/pfr_queue.sv @@
// ----------------------------------------------------------------------------
// pfr_queue: short command queue
// Two-entry FIFO that decouples the classifier from the framebuffer sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_queue import pfr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire pfr_cmd_t push_cmd,
  input  wire logic     pop,
  output logic          q_valid,
  output logic          q_full,
  output pfr_cmd_t      q_cmd
);

  pfr_cmd_t          entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign q_valid = (count != '0);
  assign q_full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_cmd   = entry[rd_ptr];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pfr_back.sv @@
// ----------------------------------------------------------------------------
// pfr_back: framebuffer sequencer
// Holds the page memory, performs read-modify-write drawing, the clearing
// sweep and refresh byte fetches, and keeps the output beat register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_back import pfr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     q_valid,
  input  wire pfr_cmd_t q_cmd,
  output logic          pop,
  output logic          init_busy,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  output logic [7:0]    out_byte,
  output logic          is_data,
  output logic          frame_last
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RECT_RD = 3'd1;
  localparam logic [2:0] ST_RECT_WR = 3'd2;
  localparam logic [2:0] ST_CLEAR   = 3'd3;
  localparam logic [2:0] ST_FETCH   = 3'd4;

  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              mem_we;

  logic [2:0]        state, state_next;
  pfr_cmd_t          cur;
  logic [COL_W-1:0]  col;
  logic [PAGE_W-1:0] page;
  logic [ADDR_W-1:0] clr_addr;

  logic [PAGE_W-1:0] pos_page;
  logic [OFF_W-1:0]  pos_off;
  logic [OFF_W-1:0]  data_off;
  logic              f_is_data;
  logic              f_last;
  logic [7:0]        f_cmd_byte;
  logic [7:0]        hdr_byte;

  logic [2:0]        lo, hi;
  logic [7:0]        mask;
  logic              out_free;
  logic              take_fetch;

  // Page memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Bit mask of the current page inside the rectangle
  always_comb begin
    lo   = (page == cur.page_first) ? cur.bit_lo : 3'd0;
    hi   = (page == cur.page_last) ? cur.bit_hi : 3'd7;
    mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
  end

  // Refresh header byte for the current position
  always_comb begin
    data_off = pos_off - OFF_W'(HEADER_LEN);
    case (pos_off[1:0])
      HDR_PAGE_CMD: hdr_byte = CMD_PAGE_ADDR;
      HDR_PAGE_NUM: hdr_byte = 8'(pos_page);
      HDR_COL_LOW:  hdr_byte = CMD_COL_LOW;
      HDR_COL_HIGH: hdr_byte = CMD_COL_HIGH;
      default:      hdr_byte = CMD_COL_LOW;
    endcase
  end

  // A fetch starts only when the output register is free by the next cycle
  assign out_free   = !m_tvalid || m_tready;
  assign take_fetch = (state == ST_IDLE) && q_valid && (q_cmd.op == OP_FETCH) && out_free;
  assign pop        = (state == ST_IDLE) && q_valid && ((q_cmd.op != OP_FETCH) || out_free);

  // Memory port control
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = {page, col};
    wr_data = cur.on ? (rd_data | mask) : (rd_data & ~mask);
    rd_addr = {page, col};
    case (state)
      ST_IDLE: begin
        rd_addr = {pos_page, data_off[COL_W-1:0]};
      end
      ST_RECT_WR: begin
        mem_we = 1'b1;
      end
      ST_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_addr;
        wr_data = 8'h00;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pop) begin
          case (q_cmd.op)
            OP_RECT:  state_next = ST_RECT_RD;
            OP_CLEAR: state_next = ST_CLEAR;
            default:  state_next = ST_FETCH;
          endcase
        end
      end
      ST_RECT_RD: begin
        state_next = ST_RECT_WR;
      end
      ST_RECT_WR: begin
        if (col == cur.col_last && page == cur.page_last) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_RECT_RD;
        end
      end
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_FETCH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      init_busy <= 1'b1;
      pos_page  <= '0;
      pos_off   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
          init_busy <= 1'b0;
        end
      end else if (pop && q_cmd.op == OP_CLEAR) begin
        clr_addr <= '0;
      end
      // Advance the refresh position on every fetch
      if (take_fetch) begin
        if (pos_off == OFF_W'(PAGE_LEN - 1)) begin
          pos_off <= '0;
          if (pos_page == PAGE_W'(PAGE_COUNT - 1)) begin
            pos_page <= '0;
          end else begin
            pos_page <= pos_page + PAGE_W'(1);
          end
        end else begin
          pos_off <= pos_off + OFF_W'(1);
        end
      end
    end
  end

  // Rectangle walk and fetch side information
  always_ff @(posedge clk) begin
    if (pop && q_cmd.op == OP_RECT) begin
      cur  <= q_cmd;
      col  <= q_cmd.col_first;
      page <= q_cmd.page_first;
    end else if (state == ST_RECT_WR) begin
      if (col == cur.col_last) begin
        col  <= cur.col_first;
        page <= page + PAGE_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
    if (take_fetch) begin
      f_is_data  <= (pos_off >= OFF_W'(HEADER_LEN));
      f_last     <= (pos_page == PAGE_W'(PAGE_COUNT - 1)) &&
                    (pos_off == OFF_W'(PAGE_LEN - 1));
      f_cmd_byte <= hdr_byte;
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FETCH) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FETCH) begin
      out_byte   <= f_is_data ? rd_data : f_cmd_byte;
      is_data    <= f_is_data;
      frame_last <= f_last;
    end
  end

  // Checks
  a_fetch_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |-> !m_tvalid)
    else $error("fetch result would overwrite a waiting beat");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_FETCH) |-> !mem_we)
    else $error("memory written outside drawing or clearing");

  a_init_in_clear: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> (state == ST_CLEAR))
    else $error("power-on clear left before finishing");

  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RECT_WR) |-> ($past(state) == ST_RECT_RD))
    else $error("rectangle write without a preceding read");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos_off <= OFF_W'(PAGE_LEN - 1))
    else $error("refresh offset out of range");

endmodule

`default_nettype wire

@@ tb/page_framebuffer_refresh_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_framebuffer_refresh_tb: self-checking bench for the page framebuffer
// Drives drawing and refresh-fetch beats into the block with bursty timing on
// the input and a stalling receiver on the output. A behavioral copy of the
// frame memory and the refresh scan predicts the refresh beats, which the script
// may type instead; each beat that leaves is compared field by field to them.
// ----------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_refresh_tb import pfr_pkg::*; ;

  localparam int FRAME_LEN = PAGE_COUNT * PAGE_LEN;

  // One drawing or fetch request, as carried by a single input beat.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] x0;
    logic [7:0] x1;
    logic [7:0] y0;
    logic [7:0] y1;
    logic       on;
  } gfx_cmd_t;

  // One refresh byte as it leaves the block.
  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       last;
  } refresh_beat_t;

  // A directed row; a typed beat overrides the predicted one.
  typedef struct packed {
    gfx_cmd_t      cmd;
    logic          typed;
    refresh_beat_t beat;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // x_start, x_end, y_start, y_end, pixel_on, zero pad
  logic [1:0]  s_tuser = '0;  // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // out_byte
  logic [0:0]  m_tuser;       // is_data
  logic        m_tlast;       // frame_last

  // Behavioral copy of the page memory and the refresh scan position.
  logic [7:0]    pixel_mem [MEM_DEPTH];
  int            scan_pos;
  int            frames_done;
  refresh_beat_t pending_beats[$];
  int            errors;
  int            beats_seen;
  int            burst_left;
  script_row_t   script[$];

  page_framebuffer_refresh u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // Sets or clears one pixel of the page memory; off-screen pixels are dropped.
  function automatic void paint(input int x, input int y, input logic on);
    if (x < SCREEN_WIDTH && y < ROWS) begin
      pixel_mem[(y / 8) * SCREEN_WIDTH + x][y % 8] = on;
    end
  endfunction

  // Applies one request to the page memory and works out the refresh byte
  // that a fetch hands out.
  function automatic void predict_action(input gfx_cmd_t c, output bit produced,
                                         output refresh_beat_t beat);
    int x_lim;
    int y_lim;
    int page;
    int off;
    produced = 1'b0;
    beat = '0;
    case (c.action)
      ACT_PIXEL: begin
        paint(c.x0, c.y0, c.on);
      end
      ACT_RECT: begin
        // Half-open bounds, clipped to the screen.
        x_lim = (c.x1 > SCREEN_WIDTH) ? SCREEN_WIDTH : c.x1;
        y_lim = (c.y1 > ROWS) ? ROWS : c.y1;
        for (int x = c.x0; x < x_lim; x++) begin
          for (int y = c.y0; y < y_lim; y++) begin
            paint(x, y, c.on);
          end
        end
      end
      ACT_CLEAR: begin
        foreach (pixel_mem[i]) pixel_mem[i] = '0;
      end
      default: begin
        page = scan_pos / PAGE_LEN;
        off = scan_pos % PAGE_LEN;
        produced = 1'b1;
        beat.is_data = (off >= HEADER_LEN);
        if (off >= HEADER_LEN) begin
          beat.data = pixel_mem[page * SCREEN_WIDTH + off - HEADER_LEN];
        end else begin
          case (off)
            HDR_PAGE_CMD: beat.data = CMD_PAGE_ADDR;
            HDR_PAGE_NUM: beat.data = page[7:0];
            HDR_COL_LOW:  beat.data = CMD_COL_LOW;
            default:      beat.data = CMD_COL_HIGH;
          endcase
        end
        beat.last = (scan_pos == FRAME_LEN - 1);
        if (beat.last) frames_done++;
        scan_pos = (scan_pos + 1) % FRAME_LEN;
      end
    endcase
  endfunction

  function automatic script_row_t row(input logic [1:0] act, input int x0, input int x1,
                                      input int y0, input int y1, input logic on,
                                      input logic typed = 1'b0, input int data = 0,
                                      input logic is_data = 1'b0);
    script_row_t r;
    r.cmd = '{act, x0[7:0], x1[7:0], y0[7:0], y1[7:0], on};
    r.typed = typed;
    r.beat = '{data[7:0], is_data, 1'b0};
    return r;
  endfunction

  // Random drawing request: mostly small on-screen shapes, some wild ones.
  function automatic gfx_cmd_t random_draw();
    gfx_cmd_t c;
    int pick;
    int tmp;
    pick = $urandom_range(0, 39);
    c = '{ACT_RECT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
          ($urandom_range(0, 3) != 0)};
    if (pick == 0) begin
      c.action = ACT_CLEAR;
    end else if (pick < 16) begin
      c.action = ACT_PIXEL;
      if ($urandom_range(0, 7) != 0) begin
        c.x0 = 8'($urandom_range(0, 131));
        c.y0 = 8'($urandom_range(0, 35));
      end
    end else if ($urandom_range(0, 15) != 0) begin
      c.x0 = 8'($urandom_range(0, 127));
      c.x1 = 8'(c.x0 + $urandom_range(0, 12));
      c.y0 = 8'($urandom_range(0, 31));
      c.y1 = 8'(c.y0 + $urandom_range(0, 10));
      // Now and then an inverted rectangle that must draw nothing.
      if ($urandom_range(0, 9) == 0) begin
        tmp = c.x0;
        c.x0 = c.x1;
        c.x1 = tmp[7:0];
      end
    end
    return c;
  endfunction

  // Offers one beat, waits for the handshake, records the prediction and then
  // either keeps the burst going or inserts a gap.
  task automatic offer(input gfx_cmd_t c, input logic typed, input refresh_beat_t typed_beat);
    refresh_beat_t beat;
    bit produced;
    s_tvalid <= 1'b1;
    s_tuser <= c.action;
    s_tdata <= {7'b0, c.on, c.y1, c.y0, c.x1, c.x0};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_action(c, produced, beat);
    if (produced) pending_beats.push_back(typed ? typed_beat : beat);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 15);
    end
  endtask

  // Stimulus: directed table first, then random bursts of draws and fetches.
  initial begin
    gfx_cmd_t c;
    int random_count;
    int n;
    foreach (pixel_mem[i]) pixel_mem[i] = '0;
    scan_pos = 0;
    frames_done = 0;
    errors = 0;
    burst_left = 0;
    random_count = 0;

    // Fresh frame header, then the first data byte of a cleared screen.
    script.push_back(row(ACT_FETCH, 0, 0, 0, 0, 0, 1, CMD_PAGE_ADDR, 0));
    script.push_back(row(ACT_FETCH, 0, 0, 0, 0, 0, 1, 0, 0));
    script.push_back(row(ACT_FETCH, 0, 0, 0, 0, 0, 1, CMD_COL_LOW, 0));
    script.push_back(row(ACT_FETCH, 0, 0, 0, 0, 0, 1, CMD_COL_HIGH, 0));
    script.push_back(row(ACT_FETCH, 0, 0, 0, 0, 0, 1, 0, 1));
    script.push_back(row(ACT_PIXEL, 1, 0, 7, 0, 1));
    script.push_back(row(ACT_FETCH, 0, 0, 0, 0, 0));
    // Corner pixel, pixels just off screen and all-ones coordinates.
    script.push_back(row(ACT_PIXEL, 127, 0, 31, 0, 1));
    script.push_back(row(ACT_PIXEL, 128, 0, 0, 0, 1));
    script.push_back(row(ACT_PIXEL, 0, 0, 32, 0, 1));
    script.push_back(row(ACT_PIXEL, 255, 255, 255, 255, 1));
    // Rectangle covering the whole bound range, clipped to the screen.
    script.push_back(row(ACT_RECT, 0, 255, 0, 255, 1));
    script.push_back(row(ACT_FETCH, 0, 0, 0, 0, 0));
    // Empty rectangles, then a partial erase.
    script.push_back(row(ACT_RECT, 10, 10, 0, 32, 0));
    script.push_back(row(ACT_RECT, 0, 128, 20, 5, 0));
    script.push_back(row(ACT_RECT, 3, 9, 1, 19, 0));
    script.push_back(row(ACT_FETCH, 0, 0, 0, 0, 0));
    script.push_back(row(ACT_PIXEL, 4, 0, 0, 0, 0));
    script.push_back(row(ACT_FETCH, 0, 0, 0, 0, 0));
    // Screen clear with every unused field set.
    script.push_back(row(ACT_CLEAR, 255, 255, 255, 255, 1));
    script.push_back(row(ACT_FETCH, 0, 0, 0, 0, 0));
    script.push_back(row(ACT_PIXEL, 6, 0, 3, 0, 1));
    script.push_back(row(ACT_FETCH, 0, 0, 0, 0, 0));
    script.push_back(row(ACT_FETCH, 255, 255, 255, 255, 1));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) offer(script[i].cmd, script[i].typed, script[i].beat);

    // Random draws and fetch runs until 560 requests and a full frame wrap.
    while (random_count < 560 || frames_done == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        n = $urandom_range(1, 24);
        repeat (n) begin
          c = '{ACT_FETCH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1))};
          offer(c, 1'b0, '0);
        end
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) offer(random_draw(), 1'b0, '0);
      end
      random_count += n;
    end

    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Receiver: changing stall patterns, plus one long hold-off to back up the block.
  initial begin
    int mode;
    bit held_off;
    held_off = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(10, 80)) begin
        @(posedge clk);
        if (!held_off && beats_seen >= 150) begin
          held_off = 1'b1;
          m_tready <= 1'b0;
          repeat (400) @(posedge clk);
        end
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Output check: each accepted beat against the oldest prediction.
  always @(posedge clk) begin
    refresh_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual data %h is_data %b last %b",
                 $time, m_tdata, m_tuser[0], m_tlast);
      end else begin
        want = pending_beats.pop_front();
        if (m_tdata !== want.data) begin
          errors++;
          $display("%0t: out_byte expected %h actual %h", $time, want.data, m_tdata);
        end
        if (m_tuser[0] !== want.is_data) begin
          errors++;
          $display("%0t: is_data expected %b actual %b", $time, want.is_data, m_tuser[0]);
        end
        if (m_tlast !== want.last) begin
          errors++;
          $display("%0t: frame_last expected %b actual %b", $time, want.last, m_tlast);
        end
      end
    end
  end

  // Watchdog for a hung block.
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
